FILE: rtl/tna_pkg.sv
// shared constants and payload types for the triangle normal and area block
package tna_pkg;

  // field and datapath widths
  localparam int COORD_BITS     = 16;
  localparam int NORM_FRAC_BITS = 15;
  localparam int NORM_BITS      = NORM_FRAC_BITS + 1;
  localparam int EDGE_BITS      = COORD_BITS + 1;
  localparam int PROD_BITS      = 2 * EDGE_BITS;
  localparam int CROSS_BITS     = PROD_BITS + 1;
  localparam int MAG_BITS       = 2 * COORD_BITS + 1;
  localparam int SQ_BITS        = 2 * MAG_BITS;
  localparam int SUM_BITS       = SQ_BITS + 2;
  localparam int AREA_BITS      = SUM_BITS / 2;
  localparam int REM_BITS       = SUM_BITS + 2 * NORM_FRAC_BITS + 4;

  // pipeline depths
  localparam int FRONT_LAT = 6;
  localparam int LANE_LAT  = (AREA_BITS > NORM_BITS) ? AREA_BITS : NORM_BITS;
  localparam int AREA_PAD  = LANE_LAT - AREA_BITS;
  localparam int NORM_PAD  = LANE_LAT - NORM_BITS;
  localparam int LANES     = 3;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] vertex_a_x;
    logic signed [COORD_BITS-1:0] vertex_a_y;
    logic signed [COORD_BITS-1:0] vertex_a_z;
    logic signed [COORD_BITS-1:0] vertex_b_x;
    logic signed [COORD_BITS-1:0] vertex_b_y;
    logic signed [COORD_BITS-1:0] vertex_b_z;
    logic signed [COORD_BITS-1:0] vertex_c_x;
    logic signed [COORD_BITS-1:0] vertex_c_y;
    logic signed [COORD_BITS-1:0] vertex_c_z;
  } tna_in_t;

  typedef struct packed {
    logic signed [NORM_BITS-1:0] normal_x;
    logic signed [NORM_BITS-1:0] normal_y;
    logic signed [NORM_BITS-1:0] normal_z;
    logic [AREA_BITS-1:0]        twice_area;
    logic                        degenerate;
  } tna_out_t;

  // squared cross components and their sum, handed to the lanes
  typedef struct packed {
    logic [SUM_BITS-1:0]           sum;
    logic [LANES-1:0][SQ_BITS-1:0] sq;
    logic [LANES-1:0]              neg;
    logic                          zero;
  } tna_sq_t;

endpackage

FILE: rtl/tna_cross.sv
// front end: edges, cross product, squared components and their sum
module tna_cross (
  input  logic             clk,
  input  logic             en,
  input  tna_pkg::tna_in_t in_data,
  output tna_pkg::tna_sq_t sq_out
);

  logic signed [tna_pkg::EDGE_BITS-1:0]  u_r [tna_pkg::LANES];
  logic signed [tna_pkg::EDGE_BITS-1:0]  v_r [tna_pkg::LANES];
  logic signed [tna_pkg::PROD_BITS-1:0]  p_r [2*tna_pkg::LANES];
  logic signed [tna_pkg::CROSS_BITS-1:0] w_r [tna_pkg::LANES];
  logic [tna_pkg::MAG_BITS-1:0]          mag_r [tna_pkg::LANES];
  logic [tna_pkg::LANES-1:0]             neg_r;
  logic [tna_pkg::LANES-1:0]             neg2_r;
  logic [tna_pkg::SQ_BITS-1:0]           sq_r [tna_pkg::LANES];
  tna_pkg::tna_sq_t                      out_r;

  logic signed [tna_pkg::COORD_BITS-1:0] va [tna_pkg::LANES];
  logic signed [tna_pkg::COORD_BITS-1:0] vb [tna_pkg::LANES];
  logic signed [tna_pkg::COORD_BITS-1:0] vc [tna_pkg::LANES];
  logic [tna_pkg::SUM_BITS-1:0]          sum_nxt;

  assign va[0] = in_data.vertex_a_x;
  assign va[1] = in_data.vertex_a_y;
  assign va[2] = in_data.vertex_a_z;
  assign vb[0] = in_data.vertex_b_x;
  assign vb[1] = in_data.vertex_b_y;
  assign vb[2] = in_data.vertex_b_z;
  assign vc[0] = in_data.vertex_c_x;
  assign vc[1] = in_data.vertex_c_y;
  assign vc[2] = in_data.vertex_c_z;

  // edge vectors from the first vertex
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < tna_pkg::LANES; i++) begin
        u_r[i] <= {vb[i][tna_pkg::COORD_BITS-1], vb[i]} - {va[i][tna_pkg::COORD_BITS-1], va[i]};
        v_r[i] <= {vc[i][tna_pkg::COORD_BITS-1], vc[i]} - {va[i][tna_pkg::COORD_BITS-1], va[i]};
      end
    end
  end

  // six partial products of the cross product
  always_ff @(posedge clk) begin
    if (en) begin
      p_r[0] <= u_r[1] * v_r[2];
      p_r[1] <= u_r[2] * v_r[1];
      p_r[2] <= u_r[2] * v_r[0];
      p_r[3] <= u_r[0] * v_r[2];
      p_r[4] <= u_r[0] * v_r[1];
      p_r[5] <= u_r[1] * v_r[0];
    end
  end

  // cross components
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < tna_pkg::LANES; i++) begin
        w_r[i] <= {p_r[2*i][tna_pkg::PROD_BITS-1], p_r[2*i]}
                - {p_r[2*i+1][tna_pkg::PROD_BITS-1], p_r[2*i+1]};
      end
    end
  end

  // sign and magnitude
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < tna_pkg::LANES; i++) begin
        neg_r[i] <= w_r[i][tna_pkg::CROSS_BITS-1];
        mag_r[i] <= w_r[i][tna_pkg::CROSS_BITS-1] ? tna_pkg::MAG_BITS'(-w_r[i])
                                                   : tna_pkg::MAG_BITS'(w_r[i]);
      end
    end
  end

  // squares
  always_ff @(posedge clk) begin
    if (en) begin
      neg2_r <= neg_r;
      for (int i = 0; i < tna_pkg::LANES; i++) begin
        sq_r[i] <= mag_r[i] * mag_r[i];
      end
    end
  end

  assign sum_nxt = tna_pkg::SUM_BITS'(sq_r[0]) + tna_pkg::SUM_BITS'(sq_r[1])
                 + tna_pkg::SUM_BITS'(sq_r[2]);

  // squared length and zero check
  always_ff @(posedge clk) begin
    if (en) begin
      out_r.sum   <= sum_nxt;
      out_r.zero  <= (sum_nxt == '0);
      out_r.neg   <= neg2_r;
      for (int i = 0; i < tna_pkg::LANES; i++) begin
        out_r.sq[i] <= sq_r[i];
      end
    end
  end

  assign sq_out = out_r;

endmodule

FILE: rtl/tna_isqrt.sv
// area lane: pipelined integer square root, one result bit per stage
module tna_isqrt (
  input  logic                           clk,
  input  logic                           en,
  input  logic [tna_pkg::SUM_BITS-1:0]   sum,
  output logic [tna_pkg::AREA_BITS-1:0]  root
);

  localparam int N = tna_pkg::AREA_BITS;

  logic [tna_pkg::SUM_BITS-1:0] x_r [N];
  logic [tna_pkg::SUM_BITS-1:0] r_r [N];
  logic [tna_pkg::AREA_BITS-1:0] res;

  for (genvar k = 0; k < N; k++) begin : g_stage
    localparam int B = N - 1 - k;
    logic [tna_pkg::SUM_BITS-1:0] xi;
    logic [tna_pkg::SUM_BITS-1:0] ri;
    logic [tna_pkg::SUM_BITS-1:0] bitv;
    logic [tna_pkg::SUM_BITS-1:0] trial;

    if (k == 0) begin : g_first
      assign xi = sum;
      assign ri = '0;
    end else begin : g_next
      assign xi = x_r[k-1];
      assign ri = r_r[k-1];
    end

    assign bitv  = tna_pkg::SUM_BITS'(1) << (2 * B);
    assign trial = ri + bitv;

    // trial subtract of the next root bit
    always_ff @(posedge clk) begin
      if (en) begin
        if (xi >= trial) begin
          x_r[k] <= xi - trial;
          r_r[k] <= (ri >> 1) + bitv;
        end else begin
          x_r[k] <= xi;
          r_r[k] <= ri >> 1;
        end
      end
    end
  end

  assign res = r_r[N-1][tna_pkg::AREA_BITS-1:0];

  // align with the normal lanes
  if (tna_pkg::AREA_PAD > 0) begin : g_pad
    logic [tna_pkg::AREA_BITS-1:0] pad_r [tna_pkg::AREA_PAD];
    always_ff @(posedge clk) begin
      if (en) begin
        pad_r[0] <= res;
        for (int i = 1; i < tna_pkg::AREA_PAD; i++) pad_r[i] <= pad_r[i-1];
      end
    end
    assign root = pad_r[tna_pkg::AREA_PAD-1];
  end else begin : g_nopad
    assign root = res;
  end

endmodule

FILE: rtl/tna_norm_lane.sv
// normal lane: one component of w / |w|, one quotient bit per stage by exact compare
module tna_norm_lane (
  input  logic                                 clk,
  input  logic                                 en,
  input  logic [tna_pkg::SUM_BITS-1:0]         sum,
  input  logic [tna_pkg::SQ_BITS-1:0]          sq,
  input  logic                                 neg,
  output logic signed [tna_pkg::NORM_BITS-1:0] norm
);

  localparam int N = tna_pkg::NORM_BITS;
  localparam int W = tna_pkg::REM_BITS;

  // remainder c^2 * 2^2F - q^2 * s, running q * s, quotient, s and sign
  logic [W-1:0]                  rem_r [N];
  logic [W-1:0]                  qs_r  [N];
  logic [tna_pkg::NORM_BITS-1:0] q_r   [N];
  logic [tna_pkg::SUM_BITS-1:0]  s_r   [N];
  logic                          neg_r [N];

  logic [tna_pkg::NORM_BITS-1:0]        q_sat;
  logic signed [tna_pkg::NORM_BITS-1:0] res;

  for (genvar k = 0; k < N; k++) begin : g_stage
    localparam int B = tna_pkg::NORM_FRAC_BITS - k;
    logic [W-1:0]                  rem_i;
    logic [W-1:0]                  qs_i;
    logic [tna_pkg::NORM_BITS-1:0] q_i;
    logic [tna_pkg::SUM_BITS-1:0]  s_i;
    logic                          neg_i;
    logic [W-1:0]                  trial;

    if (k == 0) begin : g_first
      assign rem_i = W'(sq) << (2 * tna_pkg::NORM_FRAC_BITS);
      assign qs_i  = '0;
      assign q_i   = '0;
      assign s_i   = sum;
      assign neg_i = neg;
    end else begin : g_next
      assign rem_i = rem_r[k-1];
      assign qs_i  = qs_r[k-1];
      assign q_i   = q_r[k-1];
      assign s_i   = s_r[k-1];
      assign neg_i = neg_r[k-1];
    end

    // (q + 2^B)^2 s - q^2 s = 2^(B+1) q s + 2^2B s
    assign trial = (qs_i << (B + 1)) + (W'(s_i) << (2 * B));

    always_ff @(posedge clk) begin
      if (en) begin
        s_r[k]   <= s_i;
        neg_r[k] <= neg_i;
        if (rem_i >= trial) begin
          rem_r[k] <= rem_i - trial;
          qs_r[k]  <= qs_i + (W'(s_i) << B);
          q_r[k]   <= q_i | (tna_pkg::NORM_BITS'(1) << B);
        end else begin
          rem_r[k] <= rem_i;
          qs_r[k]  <= qs_i;
          q_r[k]   <= q_i;
        end
      end
    end
  end

  // saturate exact 1.0 and apply the sign
  assign q_sat = q_r[N-1][tna_pkg::NORM_BITS-1] ? {1'b0, {(tna_pkg::NORM_BITS-1){1'b1}}}
                                                 : q_r[N-1];
  assign res   = neg_r[N-1] ? -$signed(q_sat) : $signed(q_sat);

  // align with the area lane
  if (tna_pkg::NORM_PAD > 0) begin : g_pad
    logic signed [tna_pkg::NORM_BITS-1:0] pad_r [tna_pkg::NORM_PAD];
    always_ff @(posedge clk) begin
      if (en) begin
        pad_r[0] <= res;
        for (int i = 1; i < tna_pkg::NORM_PAD; i++) pad_r[i] <= pad_r[i-1];
      end
    end
    assign norm = pad_r[tna_pkg::NORM_PAD-1];
  end else begin : g_nopad
    assign norm = res;
  end

endmodule

FILE: rtl/triangle_normal_and_area.sv
// top level: cross product front end, three normal lanes, area lane, merge and output register
//
//   channel | direction | handshake         | payload
//   in_     | input     | in_valid/in_stall | tna_pkg::tna_in_t, three vertices
//   out_    | output    | out_valid/out_stall | tna_pkg::tna_out_t, normal, area, flag
//
// one triangle per cycle while no stalled result holds the pipeline; an item passes through the
// front-end registers, the lane depth (the longer of 34 square-root stages and 16 quotient stages)
// and the output register. the lanes emit one result bit per stage, which sets the depth.
// reset (rst_n low, synchronous) clears the valid chain and the output valid flag.
// when the output holds a result and out_stall is high the whole pipeline holds
// and in_stall rises; otherwise items enter while earlier ones are in flight.
module triangle_normal_and_area (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  tna_pkg::tna_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output tna_pkg::tna_out_t out_data
);

  localparam int TOTAL = tna_pkg::FRONT_LAT + tna_pkg::LANE_LAT;

  logic                                 en;
  tna_pkg::tna_sq_t                     sq;
  logic [tna_pkg::AREA_BITS-1:0]        area;
  logic signed [tna_pkg::NORM_BITS-1:0] norm [tna_pkg::LANES];
  logic [TOTAL-1:0]                     vld_r;
  logic [tna_pkg::LANE_LAT-1:0]         deg_r;
  logic                                 out_valid_r;
  tna_pkg::tna_out_t                    out_r;
  tna_pkg::tna_out_t                    out_nxt;

  // pipeline advances unless a waiting result is stalled
  assign en       = !out_valid_r || !out_stall;
  assign in_stall = !en;

  tna_cross u_cross (
    .clk     (clk),
    .en      (en),
    .in_data (in_data),
    .sq_out  (sq)
  );

  tna_isqrt u_area (
    .clk  (clk),
    .en   (en),
    .sum  (sq.sum),
    .root (area)
  );

  for (genvar l = 0; l < tna_pkg::LANES; l++) begin : g_lane
    tna_norm_lane u_lane (
      .clk  (clk),
      .en   (en),
      .sum  (sq.sum),
      .sq   (sq.sq[l]),
      .neg  (sq.neg[l]),
      .norm (norm[l])
    );
  end

  // valid chain
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[TOTAL-2:0], in_valid};
    end
  end

  // degenerate flag follows the lanes
  always_ff @(posedge clk) begin
    if (en) begin
      deg_r <= {deg_r[tna_pkg::LANE_LAT-2:0], sq.zero};
    end
  end

  // merge lane results
  always_comb begin
    out_nxt.degenerate = deg_r[tna_pkg::LANE_LAT-1];
    out_nxt.normal_x   = out_nxt.degenerate ? '0 : norm[0];
    out_nxt.normal_y   = out_nxt.degenerate ? '0 : norm[1];
    out_nxt.normal_z   = out_nxt.degenerate ? '0 : norm[2];
    out_nxt.twice_area = out_nxt.degenerate ? '0 : area;
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= vld_r[TOTAL-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

FILE: rtl/tna_checker.sv
// port-level checks for the triangle normal and area block, bound to the top level
module tna_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input tna_pkg::tna_out_t out_data
);

  localparam logic [tna_pkg::NORM_BITS-1:0] MOST_NEG = {1'b1, {(tna_pkg::NORM_BITS-1){1'b0}}};

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // input stalls only behind a stalled result
  a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall == (out_valid && out_stall))
    else $error("input stall does not follow output");

  // degenerate result carries zero normal and area
  a_degenerate: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.degenerate |->
      out_data.normal_x == '0 && out_data.normal_y == '0 &&
      out_data.normal_z == '0 && out_data.twice_area == '0)
    else $error("degenerate result not zero");

  // saturation never yields the most negative code
  a_saturation: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.normal_x != MOST_NEG && out_data.normal_y != MOST_NEG &&
      out_data.normal_z != MOST_NEG)
    else $error("normal component out of range");

  // reset empties the output
  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result present after reset");

endmodule

bind triangle_normal_and_area tna_checker u_tna_checker (.*);
